[rtl/ncc_pkg.sv]
package ncc_pkg;

    localparam int NUM_CLASSES   = 7;
    localparam int FEATURE_LEN   = 128;
    localparam int ELEM_BITS     = 16;

    // Fixed by the field widths of the stream items.
    localparam int VALUE_BITS    = 16;
    localparam int CLASS_BITS    = 3;
    localparam int ELEM_IDX_BITS = 7;
    localparam int ACC_BITS      = 39;

    localparam int ADDR_W        = $clog2(FEATURE_LEN);
    localparam int PROD_BITS     = ELEM_BITS + VALUE_BITS;
    localparam int TREE_LEVELS   = $clog2(NUM_CLASSES);
    localparam int TREE_LEAVES   = 2 ** TREE_LEVELS;
    localparam int IDX_W         = TREE_LEVELS;

    localparam logic                       KIND_LOAD    = 1'b0;
    localparam logic                       KIND_FEATURE = 1'b1;

    localparam logic signed [ACC_BITS-1:0] THRESH_RESET = ACC_BITS'(751619277);
    // -2.0 in Q.30
    localparam logic signed [ACC_BITS-1:0] SCORE_FLOOR  = {{(ACC_BITS-31){1'b1}}, 31'd0};

    typedef struct packed {
        logic                         en;
        logic [ADDR_W-1:0]            addr;
        logic [ELEM_BITS-1:0]         wr_value;
        logic signed [VALUE_BITS-1:0] feat;
        logic                         s1_use;
        logic                         s2_upd;
        logic                         s2_last;
    } t_lane_ctl;

    typedef struct packed {
        logic                       vld;
        logic [IDX_W-1:0]           id;
        logic signed [ACC_BITS-1:0] score;
    } t_node;

    typedef struct packed {
        logic                       corner;
        logic                       accepted;
        logic signed [ACC_BITS-1:0] score;
        logic [CLASS_BITS-1:0]      class_id;
    } t_result;

endpackage

[rtl/ncc_lane.sv]
module ncc_lane (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  ncc_pkg::t_lane_ctl                        i_ctl,
    input  logic                                      i_wr_en,
    output logic signed [ncc_pkg::ACC_BITS-1:0]       o_score
);
    import ncc_pkg::*;

    logic [ELEM_BITS-1:0]         r_mem [FEATURE_LEN];
    logic signed [ELEM_BITS-1:0]  r_rd;
    logic signed [PROD_BITS-1:0]  r_prod;
    logic signed [PROD_BITS-1:0]  n_prod;
    logic signed [ACC_BITS-1:0]   r_acc;
    logic signed [ACC_BITS-1:0]   n_sum;
    logic signed [ACC_BITS-1:0]   r_score;

    // One center element per cycle is written or read; reads hold while i_ctl.en is low.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_ctl.addr] <= i_ctl.wr_value;
        end
        if (i_ctl.en) begin
            r_rd <= r_mem[i_ctl.addr];
        end
    end

    always_comb begin
        if (i_ctl.s1_use) begin
            n_prod = r_rd * $signed(i_ctl.feat);
        end else begin
            n_prod = '0;
        end
        n_sum  = r_acc + {{(ACC_BITS-PROD_BITS){r_prod[PROD_BITS-1]}}, r_prod};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_prod <= n_prod;
            if (i_ctl.s2_last) begin
                r_score <= n_sum;
            end
        end
    end

    // The accumulator restarts from zero once the last element is folded in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.en && i_ctl.s2_upd) begin
            r_acc <= i_ctl.s2_last ? '0 : n_sum;
        end
    end

    assign o_score = r_score;

endmodule

[rtl/ncc_argmax.sv]
module ncc_argmax (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [ncc_pkg::ACC_BITS-1:0]  i_scores [ncc_pkg::NUM_CLASSES],
    input  logic signed [ncc_pkg::ACC_BITS-1:0]  i_threshold,
    output logic                                 o_valid,
    output ncc_pkg::t_result                     o_result
);
    import ncc_pkg::*;

    t_node            c_node [TREE_LEVELS+1][TREE_LEAVES];
    t_node            r_node [TREE_LEVELS][TREE_LEAVES/2];
    logic             r_vld  [TREE_LEVELS];
    t_node            best;
    logic             better;
    t_result          n_result;
    t_result          r_result;
    logic             r_valid;

    always_comb begin
        for (int j = 0; j < TREE_LEAVES; j++) begin
            c_node[0][j].vld   = (j < NUM_CLASSES);
            c_node[0][j].id    = IDX_W'(j);
            c_node[0][j].score = (j < NUM_CLASSES) ? i_scores[j] : '0;
        end
        for (int l = 1; l <= TREE_LEVELS; l++) begin
            for (int j = 0; j < TREE_LEAVES; j++) begin
                if (j < TREE_LEAVES/2) begin
                    c_node[l][j] = r_node[l-1][j];
                end else begin
                    c_node[l][j] = '0;
                end
            end
        end
    end

    // Each level keeps the lower index on equal scores, so ties go to the earlier class.
    for (genvar l = 0; l < TREE_LEVELS; l++) begin : g_level
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int j = 0; j < TREE_LEAVES/2; j++) begin
                    if (c_node[l][2*j+1].vld &&
                        (!c_node[l][2*j].vld ||
                         ($signed(c_node[l][2*j+1].score) > $signed(c_node[l][2*j].score))))
                    begin
                        r_node[l][j] <= c_node[l][2*j+1];
                    end else begin
                        r_node[l][j] <= c_node[l][2*j];
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[l] <= 1'b0;
            end else if (i_en) begin
                r_vld[l] <= (l == 0) ? i_valid : r_vld[(l == 0) ? 0 : l-1];
            end
        end
    end

    always_comb begin
        best   = c_node[TREE_LEVELS][0];
        better = $signed(best.score) > SCORE_FLOOR;
        n_result.score    = better ? best.score : SCORE_FLOOR;
        n_result.class_id = better ? CLASS_BITS'(best.id) : '0;
        n_result.accepted = better ? ($signed(best.score) > i_threshold)
                                   : (SCORE_FLOOR > i_threshold);
        n_result.corner   = better ? (best.id <= IDX_W'(1)) : 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_vld[TREE_LEVELS-1];
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[rtl/nearest_centroid_classifier.sv]
// Nearest-centroid classifier.
// The slave stream carries two kinds of transaction, told apart by tuser: a
// load writes one element of one class centre, a feature element is multiplied
// against the matching element of every centre and added to that class's
// accumulator. A feature element with tlast set closes the embedding: one
// result transaction follows on the master stream with the best class, its
// score, the accept flag and the corner flag, and the accumulators restart.
// The block takes one transaction every cycle while the skid register is empty.
// Each class has its own centre memory, multiplier and accumulator; the class
// search is a registered comparison tree, so a result passes the lane and tree
// registers and the result and output registers before it shows on m_axis_tvalid.
// The threshold register is written through the cfg channel, which is always
// ready; write it only while no embedding is in flight.
// Reset clears the accumulators, the pipeline and the output, and restores
// the threshold to 0.70. Centre memories keep their contents and must be
// loaded before use. When the receiver stalls, one result waits in the output
// register and a second in a skid register; only then does s_axis_tready fall.
module nearest_centroid_classifier (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // class_index[2:0], element_index[9:3], value[25:10], zero fill
    input  logic [31:0]                          s_axis_tdata,
    // kind
    input  logic                                 s_axis_tuser,
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // class_id[2:0], score[41:3], accepted[42], use_second_corner[43], zero fill
    output logic [47:0]                          m_axis_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ncc_pkg::ACC_BITS-1:0]         i_cfg_data
);
    import ncc_pkg::*;

    logic [CLASS_BITS-1:0]        in_class;
    logic [ELEM_IDX_BITS-1:0]     in_elem;
    logic [VALUE_BITS-1:0]        in_value;
    logic                         in_acc;
    logic                         in_range;
    logic                         en;

    logic signed [ACC_BITS-1:0]   r_threshold;

    logic                         r_s1_feat;
    logic                         r_s1_use;
    logic                         r_s1_last;
    logic signed [VALUE_BITS-1:0] r_s1_value;
    logic                         r_s2_feat;
    logic                         r_s2_last;
    logic                         r_s3_valid;

    t_lane_ctl                    lane_ctl;
    logic signed [ACC_BITS-1:0]   scores [NUM_CLASSES];

    logic                         res_valid;
    t_result                      res;
    logic                         r_out_valid;
    t_result                      r_out;
    logic                         r_skid_valid;
    t_result                      r_skid;
    logic                         out_take;

    assign in_class = s_axis_tdata[CLASS_BITS-1:0];
    assign in_elem  = s_axis_tdata[CLASS_BITS +: ELEM_IDX_BITS];
    assign in_value = s_axis_tdata[CLASS_BITS+ELEM_IDX_BITS +: VALUE_BITS];
    assign in_range = int'(in_elem) < FEATURE_LEN;

    // The whole pipeline moves unless the skid register is occupied.
    assign en            = !r_skid_valid;
    assign s_axis_tready = en;
    assign in_acc        = s_axis_tvalid && en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
        end else if (i_cfg_valid) begin
            r_threshold <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_feat  <= 1'b0;
            r_s1_use   <= 1'b0;
            r_s1_last  <= 1'b0;
            r_s2_feat  <= 1'b0;
            r_s2_last  <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s1_feat  <= in_acc && (s_axis_tuser == KIND_FEATURE);
            r_s1_use   <= in_acc && (s_axis_tuser == KIND_FEATURE) && in_range;
            r_s1_last  <= in_acc && (s_axis_tuser == KIND_FEATURE) && s_axis_tlast;
            r_s2_feat  <= r_s1_feat;
            r_s2_last  <= r_s1_last;
            r_s3_valid <= r_s2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_value <= in_value;
        end
    end

    always_comb begin
        lane_ctl.en       = en;
        lane_ctl.addr     = ADDR_W'(in_elem);
        lane_ctl.wr_value = ELEM_BITS'($signed(in_value));
        lane_ctl.feat     = r_s1_value;
        lane_ctl.s1_use   = r_s1_use;
        lane_ctl.s2_upd   = r_s2_feat;
        lane_ctl.s2_last  = r_s2_last;
    end

    for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_lane
        logic wr_en;

        assign wr_en = in_acc && (s_axis_tuser == KIND_LOAD) && in_range &&
                       (int'(in_class) == c);

        ncc_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_wr_en (wr_en),
            .o_score (scores[c])
        );
    end

    ncc_argmax u_argmax (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (r_s3_valid),
        .i_scores    (scores),
        .i_threshold (r_threshold),
        .o_valid     (res_valid),
        .o_result    (res)
    );

    assign out_take = r_out_valid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 48'(r_out);

endmodule
